@@ rtl/calendar_clock_with_zone_offset_defines.svh @@
// Assertion macros for the calendar clock with zone offset.
`ifndef CALENDAR_CLOCK_WITH_ZONE_OFFSET_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_ZONE_OFFSET_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CCZ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define CCZ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

@@ rtl/ccz_pkg.sv @@
// Shared types, constants and helper functions of the calendar clock.
`timescale 1ns / 1ps

package ccz_pkg;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
  } cal_t;

  localparam cal_t CAL_RESET = '{year: 14'd0, month: 4'd1, day: 5'd1,
                                 hour: 5'd0, min: 6'd0, sec: 6'd0};

  localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [4:0]  LEAP_FEB   = 5'd29;
  localparam logic [3:0]  MONTH_LAST = 4'd12;

  localparam logic [1:0] REG_OFFSET_HOURS   = 2'd0;
  localparam logic [1:0] REG_OFFSET_MINUTES = 2'd1;
  localparam logic [1:0] REG_OFFSET_SECONDS = 2'd2;
  localparam logic [1:0] REG_SUMMER_TIME    = 2'd3;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic [13:0] year);
    logic [3:0] idx;
    idx = (month inside {[4'd1:4'd12]}) ? month - 4'd1 : 4'd0;
    if (idx == 4'd1 && year[1:0] == 2'b00) begin
      return LEAP_FEB;
    end
    return MONTH_LEN[idx];
  endfunction

  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] ones;
    if (v >= 6'd50) tens = 4'd5;
    else if (v >= 6'd40) tens = 4'd4;
    else if (v >= 6'd30) tens = 4'd3;
    else if (v >= 6'd20) tens = 4'd2;
    else if (v >= 6'd10) tens = 4'd1;
    else tens = 4'd0;
    ones = v - {tens[2:0], 3'b000} - {1'b0, tens, 1'b0};
    return {tens, ones[3:0]};
  endfunction

endpackage

@@ rtl/calendar_clock_with_zone_offset.sv @@
// Top level of the UTC calendar clock with zone offset and BCD time output.
// Each input item is a one-second tick that may first load a new UTC time
// (tuser high); the UTC calendar then advances one second and one result item
// carries the local date and time, with the configured signed zone offset and
// summer hour applied. Items flow through three registers: the input register,
// the UTC calendar update and the result register; one item is taken every
// cycle as long as results are drained. No memory needs clearing after reset.
// Configuration writes are always taken and must only be made while no item
// is in flight.
`timescale 1ns / 1ps
`include "calendar_clock_with_zone_offset_defines.svh"

module calendar_clock_with_zone_offset (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // load_second, load_minute, load_hour, load_day,
                                  // load_month, load_year
  input  logic        s_tuser,    // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // local_second, local_minute, local_hour, local_day,
                                  // local_month, local_year, bcd_hour, bcd_minute,
                                  // bcd_second
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import ccz_pkg::*;

  function automatic logic signed [5:0] clamp_hours(input logic [5:0] v);
    if ($signed(v) > 6'sd23) return 6'sd23;
    if ($signed(v) < -6'sd23) return -6'sd23;
    return $signed(v);
  endfunction

  function automatic logic signed [6:0] clamp_sixty(input logic [6:0] v);
    if ($signed(v) > 7'sd59) return 7'sd59;
    if ($signed(v) < -7'sd59) return -7'sd59;
    return $signed(v);
  endfunction

  logic signed [5:0] off_hours;
  logic signed [6:0] off_minutes;
  logic signed [6:0] off_seconds;
  logic              summer;

  logic        s0_valid;
  logic        s0_op;
  cal_t        s0_cal;
  cal_t        utc;
  cal_t        utc_next;
  logic        s1_valid;
  logic        s1_ready;
  logic        out_ready;
  logic        out_valid;
  cal_t        out_cal;
  logic [7:0]  out_bcd_hour;
  logic [7:0]  out_bcd_minute;
  logic [7:0]  out_bcd_second;

  cal_t              loc;
  logic [7:0]        loc_bcd_hour;
  logic [7:0]        loc_bcd_minute;
  logic [7:0]        loc_bcd_second;
  logic signed [6:0] oh;
  cal_t              ld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_hours   <= 6'sd0;
      off_minutes <= 7'sd0;
      off_seconds <= 7'sd0;
      summer      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_HOURS:   off_hours   <= clamp_hours(cfg_data[5:0]);
        REG_OFFSET_MINUTES: off_minutes <= clamp_sixty(cfg_data);
        REG_OFFSET_SECONDS: off_seconds <= clamp_sixty(cfg_data);
        REG_SUMMER_TIME:    summer      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid || m_tready;
  assign s1_ready  = !s1_valid || out_ready;
  assign s_tready  = !s0_valid || s1_ready;

  assign ld.sec   = s_tdata[5:0];
  assign ld.min   = s_tdata[11:6];
  assign ld.hour  = s_tdata[16:12];
  assign ld.day   = s_tdata[21:17];
  assign ld.month = s_tdata[25:22];
  assign ld.year  = s_tdata[39:26];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_tready) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s0_op  <= s_tuser;
      s0_cal <= ld;
    end
  end

  ccz_tick u_tick (
    .cur  (utc),
    .load (s0_op),
    .ld   (s0_cal),
    .nxt  (utc_next)
  );

  // UTC calendar update
  always_ff @(posedge clk) begin
    if (rst) begin
      utc      <= CAL_RESET;
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid;
      if (s0_valid) begin
        utc <= utc_next;
      end
    end
  end

  assign oh = $signed({off_hours[5], off_hours}) + $signed({6'b000000, summer});

  ccz_offset u_offset (
    .utc        (utc),
    .oh         (oh),
    .om         (off_minutes),
    .os         (off_seconds),
    .loc        (loc),
    .bcd_hour   (loc_bcd_hour),
    .bcd_minute (loc_bcd_minute),
    .bcd_second (loc_bcd_second)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      out_cal        <= loc;
      out_bcd_hour   <= loc_bcd_hour;
      out_bcd_minute <= loc_bcd_minute;
      out_bcd_second <= loc_bcd_second;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_bcd_second, out_bcd_minute, out_bcd_hour, out_cal.year,
                     out_cal.month, out_cal.day, out_cal.hour, out_cal.min, out_cal.sec};

  `CCZ_ASSERT_NXT(a_sec_advance, s0_valid && s1_ready && !s0_op, utc.sec == $past(utc.sec) + 6'd1 || utc.sec == 6'd0)
  `CCZ_ASSERT_NXT(a_utc_date_ok, s0_valid && s1_ready, utc.day != 5'd0 && utc.month != 4'd0 && utc.month <= MONTH_LAST)
  `CCZ_ASSERT_IMP(a_out_source, $rose(m_tvalid), $past(s1_valid))
  `CCZ_ASSERT_IMP(a_local_time_ok, m_tvalid, out_cal.hour <= 5'd23 && out_cal.min <= 6'd59 && out_cal.sec <= 6'd59)

endmodule

@@ rtl/ccz_tick.sv @@
// Load clamp and one-second advance of the UTC calendar.
`timescale 1ns / 1ps

module ccz_tick (
  input  ccz_pkg::cal_t cur,
  input  logic          load,
  input  ccz_pkg::cal_t ld,
  output ccz_pkg::cal_t nxt
);
  import ccz_pkg::*;

  cal_t       c;
  logic [4:0] ld_len;
  logic [4:0] len;

  always_comb begin
    c = cur;
    ld_len = 5'd0;
    if (load) begin
      c.sec  = (ld.sec > 6'd59) ? 6'd59 : ld.sec;
      c.min  = (ld.min > 6'd59) ? 6'd59 : ld.min;
      c.hour = (ld.hour > 5'd23) ? 5'd23 : ld.hour;
      if (ld.month == 4'd0) c.month = 4'd1;
      else if (ld.month > MONTH_LAST) c.month = MONTH_LAST;
      else c.month = ld.month;
      c.year = (ld.year > YEAR_MAX) ? YEAR_MAX : ld.year;
      ld_len = days_in(c.month, c.year);
      if (ld.day == 5'd0) c.day = 5'd1;
      else if (ld.day > ld_len) c.day = ld_len;
      else c.day = ld.day;
    end
  end

  always_comb begin
    len = days_in(c.month, c.year);
    nxt = c;
    if (c.sec < 6'd59) begin
      nxt.sec = c.sec + 6'd1;
    end else begin
      nxt.sec = 6'd0;
      if (c.min < 6'd59) begin
        nxt.min = c.min + 6'd1;
      end else begin
        nxt.min = 6'd0;
        if (c.hour < 5'd23) begin
          nxt.hour = c.hour + 5'd1;
        end else begin
          nxt.hour = 5'd0;
          if (c.day < len) begin
            nxt.day = c.day + 5'd1;
          end else begin
            nxt.day = 5'd1;
            if (c.month < MONTH_LAST) begin
              nxt.month = c.month + 4'd1;
            end else begin
              nxt.month = 4'd1;
              nxt.year = (c.year >= YEAR_MAX) ? 14'd0 : c.year + 14'd1;
            end
          end
        end
      end
    end
  end

endmodule

@@ rtl/ccz_offset.sv @@
// Zone offset add with carries through the date, plus BCD of the local time.
`timescale 1ns / 1ps

module ccz_offset (
  input  ccz_pkg::cal_t      utc,
  input  logic signed [6:0]  oh,
  input  logic signed [6:0]  om,
  input  logic signed [6:0]  os,
  output ccz_pkg::cal_t      loc,
  output logic [7:0]         bcd_hour,
  output logic [7:0]         bcd_minute,
  output logic [7:0]         bcd_second
);
  import ccz_pkg::*;

  logic signed [7:0] sec_s;
  logic signed [7:0] min_s;
  logic signed [7:0] hour_s;
  logic signed [7:0] sec_f;
  logic signed [7:0] min_f;
  logic signed [7:0] hour_f;
  logic signed [1:0] mc;
  logic signed [1:0] hc;
  logic signed [2:0] dc;
  logic signed [6:0] day_s;
  logic [3:0]        month_p;
  logic [13:0]       year_p;
  logic [4:0]        len;

  always_comb begin
    sec_s = $signed({2'b00, utc.sec}) + $signed({os[6], os});
    if (sec_s < 8'sd0) begin
      sec_f = sec_s + 8'sd60;
      mc = -2'sd1;
    end else if (sec_s > 8'sd59) begin
      sec_f = sec_s - 8'sd60;
      mc = 2'sd1;
    end else begin
      sec_f = sec_s;
      mc = 2'sd0;
    end

    min_s = $signed({2'b00, utc.min}) + $signed({om[6], om}) + $signed({{6{mc[1]}}, mc});
    if (min_s < 8'sd0) begin
      min_f = min_s + 8'sd60;
      hc = -2'sd1;
    end else if (min_s > 8'sd59) begin
      min_f = min_s - 8'sd60;
      hc = 2'sd1;
    end else begin
      min_f = min_s;
      hc = 2'sd0;
    end

    hour_s = $signed({3'b000, utc.hour}) + $signed({oh[6], oh})
           + $signed({{6{hc[1]}}, hc});
    if (hour_s < 8'sd0) begin
      hour_f = hour_s + 8'sd24;
      dc = -3'sd1;
    end else if (hour_s > 8'sd47) begin
      hour_f = hour_s - 8'sd48;
      dc = 3'sd2;
    end else if (hour_s > 8'sd23) begin
      hour_f = hour_s - 8'sd24;
      dc = 3'sd1;
    end else begin
      hour_f = hour_s;
      dc = 3'sd0;
    end

    day_s = $signed({2'b00, utc.day}) + $signed({{4{dc[2]}}, dc});
    len = days_in(utc.month, utc.year);

    loc.sec  = sec_f[5:0];
    loc.min  = min_f[5:0];
    loc.hour = hour_f[4:0];
    loc.day  = day_s[4:0];
    loc.month = utc.month;
    loc.year  = utc.year;
    month_p = utc.month;
    year_p  = utc.year;

    if (day_s < 7'sd1) begin
      if (utc.month <= 4'd1) begin
        month_p = MONTH_LAST;
        year_p = (utc.year == 14'd0) ? YEAR_MAX : utc.year - 14'd1;
      end else begin
        month_p = utc.month - 4'd1;
      end
      loc.month = month_p;
      loc.year  = year_p;
      loc.day   = days_in(month_p, year_p);
    end else if (day_s > $signed({2'b00, len})) begin
      loc.day = day_s[4:0] - len;
      if (utc.month >= MONTH_LAST) begin
        loc.month = 4'd1;
        loc.year = (utc.year >= YEAR_MAX) ? 14'd0 : utc.year + 14'd1;
      end else begin
        loc.month = utc.month + 4'd1;
      end
    end
  end

  assign bcd_hour   = to_bcd({1'b0, loc.hour});
  assign bcd_minute = to_bcd(loc.min);
  assign bcd_second = to_bcd(loc.sec);

endmodule

@@ verif/tb.sv @@
// Testbench for the calendar clock with zone offset: random and directed ticks.
`timescale 1ns / 1ps

module tb;

  localparam int PIPE_LAT = 3;
  localparam int SETTLE = PIPE_LAT + 3;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } tick_load_t;

  typedef struct packed {
    logic [7:0]  bcd_second;
    logic [7:0]  bcd_minute;
    logic [7:0]  bcd_hour;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } wall_time_t;

  class calendar_scoreboard;
    int utc_sec, utc_min, utc_hour, utc_day, utc_month, utc_year;
    bit [5:0] zone_h;
    bit [6:0] zone_m, zone_s;
    bit summer;
    wall_time_t expected_q[$];
    int errors;
    int checked;

    function new();
      utc_sec = 0; utc_min = 0; utc_hour = 0;
      utc_day = 1; utc_month = 1; utc_year = 0;
      zone_h = '0; zone_m = '0; zone_s = '0; summer = 1'b0;
      errors = 0; checked = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int days_of_month(int m, int y);
      case (m)
        2: return (y % 4 == 0) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    function bit [7:0] two_digit(int v);
      return {4'(v / 10), 4'(v % 10)};
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        ccz_pkg::REG_OFFSET_HOURS:   zone_h = val[5:0];
        ccz_pkg::REG_OFFSET_MINUTES: zone_m = val;
        ccz_pkg::REG_OFFSET_SECONDS: zone_s = val;
        ccz_pkg::REG_SUMMER_TIME:    summer = val[0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit load, tick_load_t ld);
      int oh, om, os, ts, tm, th, td, tmo, ty, len;
      wall_time_t w;
      if (load) begin
        utc_sec = clip(int'(ld.second), 0, 59);
        utc_min = clip(int'(ld.minute), 0, 59);
        utc_hour = clip(int'(ld.hour), 0, 23);
        utc_month = clip(int'(ld.month), 1, 12);
        utc_year = clip(int'(ld.year), 0, 9999);
        utc_day = clip(int'(ld.day), 1, days_of_month(utc_month, utc_year));
      end
      utc_sec++;
      if (utc_sec > 59) begin
        utc_sec = 0;
        utc_min++;
        if (utc_min > 59) begin
          utc_min = 0;
          utc_hour++;
          if (utc_hour > 23) begin
            utc_hour = 0;
            utc_day++;
            if (utc_day > days_of_month(utc_month, utc_year)) begin
              utc_day = 1;
              utc_month++;
              if (utc_month > 12) begin
                utc_month = 1;
                utc_year = (utc_year >= 9999) ? 0 : utc_year + 1;
              end
            end
          end
        end
      end

      oh = clip(int'($signed(zone_h)), -23, 23) + int'(summer);
      om = clip(int'($signed(zone_m)), -59, 59);
      os = clip(int'($signed(zone_s)), -59, 59);
      ts = utc_sec + os;
      tm = utc_min;
      th = utc_hour;
      td = utc_day;
      tmo = utc_month;
      ty = utc_year;
      if (ts < 0) begin
        ts += 60; tm--;
      end else if (ts > 59) begin
        ts -= 60; tm++;
      end
      tm += om;
      if (tm < 0) begin
        tm += 60; th--;
      end else if (tm > 59) begin
        tm -= 60; th++;
      end
      th += oh;
      if (th < 0) begin
        th += 24; td--;
      end else begin
        while (th > 23) begin
          th -= 24; td++;
        end
      end
      if (td < 1) begin
        tmo--;
        if (tmo < 1) begin
          tmo = 12;
          ty = (ty <= 0) ? 9999 : ty - 1;
        end
        td = days_of_month(tmo, ty);
      end else begin
        len = days_of_month(tmo, ty);
        if (td > len) begin
          td -= len;
          tmo++;
          if (tmo > 12) begin
            tmo = 1;
            ty = (ty >= 9999) ? 0 : ty + 1;
          end
        end
      end

      w.second = 6'(ts);
      w.minute = 6'(tm);
      w.hour = 5'(th);
      w.day = 5'(td);
      w.month = 4'(tmo);
      w.year = 14'(ty);
      w.bcd_hour = two_digit(th);
      w.bcd_minute = two_digit(tm);
      w.bcd_second = two_digit(ts);
      expected_q.push_back(w);
    endfunction

    function void field_ok(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(wall_time_t got);
      wall_time_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      field_ok("local_second", e.second, got.second);
      field_ok("local_minute", e.minute, got.minute);
      field_ok("local_hour", e.hour, got.hour);
      field_ok("local_day", e.day, got.day);
      field_ok("local_month", e.month, got.month);
      field_ok("local_year", e.year, got.year);
      field_ok("bcd_hour", e.bcd_hour, got.bcd_hour);
      field_ok("bcd_minute", e.bcd_minute, got.bcd_minute);
      field_ok("bcd_second", e.bcd_second, got.bcd_second);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  calendar_scoreboard sb = new();
  bit quiet = 1'b0;

  calendar_clock_with_zone_offset dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("calendar_clock_with_zone_offset verification failed");
    $finish;
  end

  // drain results; stall at random and once for a long stretch
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_left == 0 && !hold_done && sb.checked >= 100) begin
        hold_done = 1'b1;
        stall_left = 80;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [39:0] pack_load(int sec, int mn, int hr, int dy, int mo, int yr);
    tick_load_t ld;
    ld.second = 6'(sec);
    ld.minute = 6'(mn);
    ld.hour = 5'(hr);
    ld.day = 5'(dy);
    ld.month = 4'(mo);
    ld.year = 14'(yr);
    return ld;
  endfunction

  task automatic send_item(input bit load, input logic [39:0] data);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= load;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_tick(load, data);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_zone(input logic [6:0] h, input logic [6:0] m, input logic [6:0] s,
                          input logic dst);
    write_reg(ccz_pkg::REG_OFFSET_HOURS, h);
    write_reg(ccz_pkg::REG_OFFSET_MINUTES, m);
    write_reg(ccz_pkg::REG_OFFSET_SECONDS, s);
    write_reg(ccz_pkg::REG_SUMMER_TIME, {6'd0, dst});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    int spins;
    spins = 0;
    while (sb.expected_q.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic end_phase();
    s_tvalid <= 1'b0;
    wait_drain();
  endtask

  task automatic random_zone();
    int h, m, s;
    case ($urandom_range(0, 3))
      0: begin
        h = $urandom_range(0, 1) ? 23 : -23;
        m = $urandom_range(0, 1) ? 59 : -59;
        s = $urandom_range(0, 1) ? 59 : -59;
      end
      1: begin
        h = $urandom_range(0, 127);
        m = $urandom_range(0, 127);
        s = $urandom_range(0, 127);
      end
      2: begin
        h = $urandom_range(0, 46) - 23;
        m = $urandom_range(0, 118) - 59;
        s = $urandom_range(0, 118) - 59;
      end
      default: begin
        h = 0; m = 0; s = 0;
      end
    endcase
    set_zone(7'(h), 7'(m), 7'(s), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [39:0] near_edge();
    int y, m, d, hr, mn, sc;
    case ($urandom_range(0, 4))
      0: y = 0;
      1: y = 9999;
      2: y = 4 * $urandom_range(0, 2499);
      3: y = $urandom_range(9996, 9999);
      default: y = $urandom_range(0, 9999);
    endcase
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 2))
        0: m = 1;
        1: m = 2;
        default: m = 12;
      endcase
    end else begin
      m = $urandom_range(1, 12);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: d = sb.days_of_month(m, y);
      5, 6, 7: d = 1;
      default: d = $urandom_range(1, 31);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: hr = 23;
      6, 7: hr = 0;
      default: hr = $urandom_range(0, 23);
    endcase
    mn = ($urandom_range(0, 9) < 6) ? 59 : $urandom_range(0, 59);
    sc = ($urandom_range(0, 9) < 6) ? $urandom_range(55, 59) : $urandom_range(0, 59);
    return pack_load(sc, mn, hr, d, m, y);
  endfunction

  initial begin
    int n, r, k, phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // largest forward offset with summer hour
    quiet = 1'b1;
    set_zone(7'd23, 7'd59, 7'd59, 1'b1);
    send_item(1'b1, pack_load(50, 59, 23, 31, 12, 9999));
    send_item(1'b1, 40'hFF_FFFF_FFFF);
    send_item(1'b1, 40'h0);
    send_item(1'b1, pack_load(59, 59, 23, 28, 2, 2024));
    send_item(1'b0, 40'hFF_FFFF_FFFF);
    send_item(1'b1, pack_load(59, 59, 23, 31, 2, 2023));
    send_item(1'b1, pack_load(59, 59, 23, 30, 2, 2024));
    send_item(1'b1, pack_load(30, 30, 12, 0, 0, 100));
    send_item(1'b1, pack_load(60, 60, 24, 15, 6, 2000));
    send_item(1'b1, pack_load(59, 59, 23, 30, 4, 2023));
    send_item(1'b0, 40'h0);
    end_phase();

    // largest backward offset: month and year borrow
    set_zone(-7'sd23, -7'sd59, -7'sd59, 1'b0);
    send_item(1'b1, pack_load(0, 0, 0, 1, 1, 0));
    send_item(1'b1, pack_load(10, 0, 0, 1, 3, 2024));
    send_item(1'b1, pack_load(10, 0, 0, 1, 3, 2023));
    send_item(1'b0, 40'h0);
    send_item(1'b0, 40'h0);
    end_phase();

    // raw register values beyond the clamp limits
    set_zone(7'b010_0000, 7'b100_0000, 7'b011_1111, 1'b1);
    send_item(1'b1, pack_load(0, 0, 0, 1, 5, 9999));
    send_item(1'b1, pack_load(59, 59, 23, 31, 1, 5000));
    end_phase();
    set_zone(7'b001_1111, 7'b011_1111, 7'b100_0000, 1'b0);
    send_item(1'b1, pack_load(59, 59, 23, 31, 12, 9999));
    send_item(1'b1, pack_load(0, 0, 0, 1, 1, 0));
    end_phase();

    for (phase = 0; phase < 6; phase++) begin
      quiet = (phase == 0);
      random_zone();
      n = 0;
      while (n < 70) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_item(1'b1, near_edge());
          n++;
          k = $urandom_range(0, 5);
          repeat (k) begin
            send_item(1'b0, {8'($urandom), 32'($urandom)});
            n++;
          end
        end else if (r < 75) begin
          send_item(1'b1, {8'($urandom), 32'($urandom)});
          n++;
        end else begin
          send_item(1'b0, {8'($urandom), 32'($urandom)});
          n++;
        end
        if (phase == 2 && n >= 35 && n < 42) begin
          s_tvalid <= 1'b0;
          wait_drain();
          n = 42;
        end
      end
      end_phase();
    end

    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d result items outstanding, expected 0, actual %0d", $time,
               sb.expected_q.size(), sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("calendar_clock_with_zone_offset verification clean");
    end else begin
      $display("calendar_clock_with_zone_offset verification failed");
    end
    $finish;
  end

endmodule

@@ calendar_clock_with_zone_offset.f @@
+incdir+rtl
rtl/ccz_pkg.sv
rtl/ccz_tick.sv
rtl/ccz_offset.sv
rtl/calendar_clock_with_zone_offset.sv
verif/tb.sv
